// ----- hw/rtl/bmhq_pkg.sv -----
// Shared types and constants of the binary min-heap priority queue.
package bmhq_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INSERT  = 2'd0;
    localparam kind_t KIND_EXTRACT = 2'd1;
    localparam kind_t KIND_PEEK    = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ROOT,
        S_GOT_ROOT,
        S_GOT_LAST,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/binary_min_heap_queue_unit.sv -----
// Binary min-heap priority queue of (key, tag) entries held in one synchronous RAM.
//
// Input stream (s_axis): one transaction is one operation. tuser carries the
// operation (insert, extract minimum, peek minimum), tdata the key and tag
// to insert. Output stream (m_axis): exactly one transaction per operation,
// with the status in tuser and, in tdata, the entry count and the minimum entry or zero.
//
// Each operation runs alone: every sift step reads the heap RAM through its
// single registered read port, compares and writes back, with the sifting
// entry in a register. An insert climbs from the free slot at the end,
// reading each parent and comparing; an extract reads the root, moves the
// last entry to the root and descends, reading the left and then the right
// child and comparing. A peek, or an extract that empties the queue, reads
// only the root, and a rejected operation goes straight to its result. The
// block returns to idle, ready for the next operation, as the result is registered.
//
// Reset empties the queue at once; RAM contents are not cleared and a slot
// at or beyond the count never reaches a result. The result sits in an output
// register: the next operation is accepted while it waits, and the block only
// holds back the following result until the receiver takes the pending one.
module binary_min_heap_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] entry_key, [47:32] entry_tag
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_key, [47:32] out_tag,
                                        // [56:48] entry_count, [63:57] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import bmhq_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    kind_t            kind_reg, kind_next;
    entry_t           cur_reg, cur_next;
    entry_t           lc_reg, lc_next;
    logic             rc_ok_reg, rc_ok_next;
    status_t          res_status_reg, res_status_next;
    entry_t           res_entry_reg, res_entry_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    entry_t           out_entry_reg, out_entry_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    entry_t           heap_mem [CAPACITY];
    entry_t           rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic             in_fire;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W-1:0] lc_idx;
    logic [CNT_W-1:0] rc_idx;
    logic [IDX_W-1:0] parent_idx;
    logic [CNT_W-1:0] count_dec;
    logic             take_left;
    logic             take_right;
    logic [KEY_W-1:0] pick_key;
    logic             out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_full       = (count_reg == CNT_W'(CAPACITY));
    assign is_empty      = (count_reg == '0);
    assign lc_idx        = {pos_reg, 1'b1};
    assign rc_idx        = lc_idx + CNT_W'(1);
    assign parent_idx    = (pos_reg - IDX_W'(1)) >> 1;
    assign count_dec     = count_reg - CNT_W'(1);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Child selection: left first if strictly smaller, then right against the pick.
    assign take_left  = (lc_reg.key < cur_reg.key);
    assign pick_key   = take_left ? lc_reg.key : cur_reg.key;
    assign take_right = rc_ok_reg && (rd_data_reg.key < pick_key);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'b0, out_count_reg, out_entry_reg.tag, out_entry_reg.key};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (s_axis_tuser == KIND_INSERT)
                        state_next = is_full ? S_DONE : S_UP_RD;
                    else if (s_axis_tuser == KIND_EXTRACT || s_axis_tuser == KIND_PEEK)
                        state_next = is_empty ? S_DONE : S_RD_ROOT;
                    else
                        state_next = S_DONE;
                end
            end
            S_RD_ROOT:
                state_next = S_GOT_ROOT;
            S_GOT_ROOT:
            begin
                if (kind_reg == KIND_PEEK || count_dec == '0)
                    state_next = S_DONE;
                else
                    state_next = S_GOT_LAST;
            end
            S_GOT_LAST:
                state_next = S_DN_RDL;
            S_UP_RD:
                state_next = (pos_reg == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:
                state_next = (cur_reg.key < rd_data_reg.key) ? S_UP_RD : S_DONE;
            S_DN_RDL:
                state_next = (lc_idx < count_reg) ? S_DN_RDR : S_DONE;
            S_DN_RDR:
                state_next = S_DN_CMP;
            S_DN_CMP:
                state_next = (take_left || take_right) ? S_DN_RDL : S_DONE;
            S_DONE:
                state_next = out_free ? S_IDLE : S_DONE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        kind_next       = kind_reg;
        cur_next        = cur_reg;
        lc_next         = lc_reg;
        rc_ok_next      = rc_ok_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = cur_reg;
        mem_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next       = s_axis_tuser;
                    cur_next.key    = s_axis_tdata[KEY_W-1:0];
                    cur_next.tag    = s_axis_tdata[KEY_W +: TAG_W];
                    res_status_next = ST_DONE;
                    res_entry_next  = '0;
                    priority if (s_axis_tuser == KIND_INSERT)
                    begin
                        if (is_full)
                            res_status_next = ST_FULL;
                        else
                        begin
                            pos_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (s_axis_tuser == KIND_EXTRACT || s_axis_tuser == KIND_PEEK)
                    begin
                        if (is_empty)
                            res_status_next = ST_EMPTY;
                    end
                    else
                        res_status_next = ST_DONE;
                end
            end
            S_RD_ROOT:
                mem_raddr = '0;
            S_GOT_ROOT:
            begin
                res_entry_next = rd_data_reg;
                if (kind_reg == KIND_EXTRACT)
                begin
                    count_next = count_dec;
                    mem_raddr  = count_dec[IDX_W-1:0];
                end
            end
            S_GOT_LAST:
            begin
                cur_next = rd_data_reg;
                pos_next = '0;
            end
            S_UP_RD:
            begin
                mem_raddr = parent_idx;
                // root reached: settle the entry here
                if (pos_reg == '0)
                    mem_we = 1'b1;
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cur_reg.key < rd_data_reg.key)
                begin
                    mem_wdata = rd_data_reg;
                    pos_next  = parent_idx;
                end
            end
            S_DN_RDL:
            begin
                mem_raddr = lc_idx[IDX_W-1:0];
                if (!(lc_idx < count_reg))
                    mem_we = 1'b1;
            end
            S_DN_RDR:
            begin
                mem_raddr  = rc_idx[IDX_W-1:0];
                lc_next    = rd_data_reg;
                rc_ok_next = (rc_idx < count_reg);
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                priority if (take_right)
                begin
                    mem_wdata = rd_data_reg;
                    pos_next  = rc_idx[IDX_W-1:0];
                end
                else if (take_left)
                begin
                    mem_wdata = lc_reg;
                    pos_next  = lc_idx[IDX_W-1:0];
                end
                else
                    mem_wdata = cur_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                    out_count_next  = count_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Heap RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            heap_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= heap_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        kind_reg       <= kind_next;
        cur_reg        <= cur_next;
        lc_reg         <= lc_next;
        rc_ok_reg      <= rc_ok_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

endmodule

// ----- hw/rtl/bmhq_checker.sv -----
// Port-level checks of the heap queue and their binding to the top level.
module bmhq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import bmhq_pkg::*;

    // Hold a stalled result transaction unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[56:48] <= CNT_W'(CAPACITY) && m_axis_tdata[63:57] == '0)
        else $error("entry count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |->
            m_axis_tdata[47:0] == '0 && m_axis_tdata[56:48] == CNT_W'(CAPACITY))
        else $error("full rejection with wrong payload or count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |->
            m_axis_tdata[47:0] == '0 && m_axis_tdata[56:48] == '0)
        else $error("empty report with entries held");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/binary_min_heap_queue_checker.sv -----
// Stream monitor that tracks the heap contents and checks every result transaction.
module binary_min_heap_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] entry_key, [47:32] entry_tag
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // [31:0] out_key, [47:32] out_tag, [56:48] entry_count
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          fail_count,
    output int          pending_count
);
    import bmhq_pkg::*;

    typedef struct {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic [CNT_W-1:0]   count;
    } heap_result_t;

    entry_t       heap_mem [CAPACITY];
    int           heap_size;
    int           mismatches;
    heap_result_t result_q [$];

    initial
    begin
        mismatches    = 0;
        heap_size     = 0;
    end

    task automatic swap_slots(input int a, input int b);
        entry_t t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endtask

    // Apply one operation to the shadow heap and return the result it must give.
    task automatic apply_op(input kind_t kind, input logic [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag, output heap_result_t res);
        int pos;
        int up;
        int lc;
        int rc;
        int pick;
        res.status = ST_DONE;
        res.key    = '0;
        res.tag    = '0;
        if (kind == KIND_INSERT)
        begin
            if (heap_size >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                pos               = heap_size;
                heap_mem[pos].key = key;
                heap_mem[pos].tag = tag;
                heap_size++;
                // climb only while strictly smaller than the parent
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (!(heap_mem[pos].key < heap_mem[up].key))
                        break;
                    swap_slots(pos, up);
                    pos = up;
                end
            end
        end
        else if (kind == KIND_EXTRACT || kind == KIND_PEEK)
        begin
            if (heap_size == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.key = heap_mem[0].key;
                res.tag = heap_mem[0].tag;
                if (kind == KIND_EXTRACT)
                begin
                    heap_size--;
                    heap_mem[0] = heap_mem[heap_size];
                    pos = 0;
                    forever
                    begin
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        pick = pos;
                        if (lc < heap_size && heap_mem[lc].key < heap_mem[pos].key)
                            pick = lc;
                        if (rc < heap_size && heap_mem[rc].key < heap_mem[pick].key)
                            pick = rc;
                        if (pick == pos)
                            break;
                        swap_slots(pos, pick);
                        pos = pick;
                    end
                end
            end
        end
        res.count = heap_size[CNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        heap_result_t exp_res;
        heap_result_t new_res;
        if (rst_n)
        begin
            // check the outgoing transaction first: it can never belong to an item taken now
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: tdata %0h tuser %0h",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    check_field("status", 64'(exp_res.status), 64'(m_axis_tuser));
                    check_field("out_key", 64'(exp_res.key), 64'(m_axis_tdata[31:0]));
                    check_field("out_tag", 64'(exp_res.tag), 64'(m_axis_tdata[47:32]));
                    check_field("entry_count", 64'(exp_res.count),
                                64'(m_axis_tdata[56:48]));
                    check_field("tdata padding", 64'(0), 64'(m_axis_tdata[63:57]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32], new_res);
                result_q.push_back(new_res);
            end
        end
        fail_count    <= mismatches;
        pending_count <= result_q.size();
    end

endmodule

// ----- test/tb_binary_min_heap_queue_unit.sv -----
// Top-level testbench of the heap queue: stimulus, flow control, watchdog and verdict.
module tb_binary_min_heap_queue_unit;
    import bmhq_pkg::*;

    localparam kind_t KIND_UNUSED  = 2'd3;
    localparam int    TOTAL_ITEMS  = 1450;
    localparam int    QUIET_FROM   = TOTAL_ITEMS - 150;
    localparam int    HOLD_AT      = 60;
    localparam int    HOLD_CYCLES  = 200;
    localparam int    DRAIN_CYCLES = 40;
    localparam int    STALL_LIMIT  = 2000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // [31:0] entry_key, [47:32] entry_tag
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [31:0] out_key, [47:32] out_tag, [56:48] entry_count
    logic [1:0]  m_axis_tuser;          // [1:0] status

    int fail_count;
    int pending_count;
    int items_sent     = 0;
    int send_idle_pct  = 25;
    int recv_idle_pct  = 25;
    int stall_cycles   = 0;
    bit long_hold_done = 1'b0;

    always #5 clk = ~clk;

    binary_min_heap_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    binary_min_heap_queue_checker heap_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one operation, possibly after a short gap, and hold it until taken.
    task automatic send_op(input kind_t kind, input logic [31:0] key, input logic [15:0] tag);
        if (items_sent < QUIET_FROM && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, key};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(0, 5))
            0, 1:    k = $urandom;
            2, 3:    k = $urandom_range(0, 7);          // dense ties
            4:       k = 32'h0001_0000 * $urandom_range(0, 20);
            default:
                case ($urandom_range(0, 4))
                    0:       k = 32'h0000_0000;
                    1:       k = 32'hFFFF_FFFF;
                    2:       k = 32'h7FFF_FFFF;
                    3:       k = 32'h8000_0000;
                    default: k = 32'h0001_0000;
                endcase
        endcase
        return k;
    endfunction

    task automatic random_op(input int ins_w, input int ext_w, input int peek_w);
        int    r;
        kind_t kind;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            kind = KIND_INSERT;
        else if (r < ins_w + ext_w)
            kind = KIND_EXTRACT;
        else if (r < ins_w + ext_w + peek_w)
            kind = KIND_PEEK;
        else
            kind = KIND_UNUSED;
        send_op(kind, pick_key(), 16'($urandom));
    endtask

    initial
    begin
        int phase_len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap, extremes, ties and the unused code
        send_op(KIND_PEEK,    32'hFFFF_FFFF, 16'hFFFF);
        send_op(KIND_EXTRACT, 32'h0000_0000, 16'h0000);
        send_op(KIND_UNUSED,  32'hFFFF_FFFF, 16'hFFFF);
        send_op(KIND_INSERT,  32'hFFFF_FFFF, 16'hFFFF);
        send_op(KIND_INSERT,  32'h0000_0000, 16'h0000);
        send_op(KIND_INSERT,  32'h0001_8000, 16'h1234);
        send_op(KIND_INSERT,  32'h0001_8000, 16'hABCD);
        send_op(KIND_INSERT,  32'h0001_8000, 16'h5555);
        send_op(KIND_INSERT,  32'h0001_0000, 16'h00FF);
        send_op(KIND_INSERT,  32'hFFFF_FFFF, 16'h8001);
        send_op(KIND_PEEK,    32'h0000_0000, 16'h0000);
        send_op(KIND_UNUSED,  32'h1234_5678, 16'h9ABC);
        repeat (8) send_op(KIND_EXTRACT, 32'h0, 16'h0);
        send_op(KIND_PEEK,    32'h0, 16'h0);

        // fill past capacity so inserts get rejected
        repeat (280) random_op(95, 2, 2);
        // drain past empty
        recv_idle_pct = 10;
        repeat (300) random_op(3, 90, 5);

        while (items_sent < TOTAL_ITEMS)
        begin
            phase_len     = $urandom_range(40, 160);
            send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
            recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            case ($urandom_range(0, 2))
                0:       repeat (phase_len) if (items_sent < TOTAL_ITEMS) random_op(85, 8, 5);
                1:       repeat (phase_len) if (items_sent < TOTAL_ITEMS) random_op(10, 75, 12);
                default: repeat (phase_len) if (items_sent < TOTAL_ITEMS) random_op(45, 38, 14);
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: short random stalls, one long hold-off to back the block up.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && items_sent >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (items_sent < QUIET_FROM && $urandom_range(0, 99) < recv_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: give up when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

// ----- binary_min_heap_queue_unit.f -----
hw/rtl/bmhq_pkg.sv
hw/rtl/binary_min_heap_queue_unit.sv
hw/rtl/bmhq_checker.sv
test/binary_min_heap_queue_checker.sv
test/tb_binary_min_heap_queue_unit.sv
